FILE: hw/rtl/u2u8_pkg.sv
`default_nettype none

package u2u8_pkg;

    // input item: one utf-16 code unit with end mark
    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } unit_item_t;

    // output item: one utf-8 byte with end-of-run flag
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
    } byte_item_t;

    // encoded code point waiting for the serializer
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } enc_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] HIGH_SUR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SUR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] MAX_ONE_BYTE   = 21'h7F;
    localparam logic [20:0] MAX_TWO_BYTE   = 21'h7FF;
    localparam logic [20:0] MAX_THREE_BYTE = 21'hFFFF;
    localparam logic [7:0]  LEAD_TWO       = 8'hC0;
    localparam logic [7:0]  LEAD_THREE     = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
    localparam logic [7:0]  CONT_MARK      = 8'h80;

endpackage

`default_nettype wire

FILE: hw/rtl/u2u8_front.sv
`default_nettype none

module u2u8_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  unit_valid,
    output logic                       unit_stall,
    input  wire u2u8_pkg::unit_item_t  unit_item,
    input  wire u2u8_pkg::q_status_t   q_status,
    output logic                       push,
    output u2u8_pkg::enc_entry_t       push_entry
);

    logic [20:0] pending_reg;
    logic [20:0] pending_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic        accept;
    logic        is_zero;
    logic        is_high;
    logic        is_low;
    logic [20:0] code_point;
    logic [15:0] unit;

    assign unit       = unit_item.code_unit;
    assign unit_stall = q_status.full;
    assign accept     = unit_valid && !q_status.full;

    // classify the unit
    assign is_zero = (unit == 16'h0000);
    assign is_high = (unit >= u2u8_pkg::HIGH_SUR_FIRST) && (unit <= u2u8_pkg::HIGH_SUR_LAST);
    assign is_low  = (unit >= u2u8_pkg::LOW_SUR_FIRST) && (unit <= u2u8_pkg::LOW_SUR_LAST);

    // code point completed by this unit
    always_comb
    begin
        if (is_low)
        begin
            code_point = pending_reg | {11'd0, 10'(unit - u2u8_pkg::LOW_SUR_FIRST)};
        end
        else
        begin
            code_point = {5'd0, unit};
        end
    end

    // utf-8 byte layout of the code point
    always_comb
    begin
        push_entry = '0;
        if (code_point <= u2u8_pkg::MAX_ONE_BYTE)
        begin
            push_entry.bytes[0] = code_point[7:0];
            push_entry.last_idx = 2'd0;
        end
        else if (code_point <= u2u8_pkg::MAX_TWO_BYTE)
        begin
            push_entry.bytes[0] = u2u8_pkg::LEAD_TWO | {3'd0, code_point[10:6]};
            push_entry.bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, code_point[5:0]};
            push_entry.last_idx = 2'd1;
        end
        else if (code_point <= u2u8_pkg::MAX_THREE_BYTE)
        begin
            push_entry.bytes[0] = u2u8_pkg::LEAD_THREE | {4'd0, code_point[15:12]};
            push_entry.bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, code_point[11:6]};
            push_entry.bytes[2] = u2u8_pkg::CONT_MARK | {2'd0, code_point[5:0]};
            push_entry.last_idx = 2'd2;
        end
        else
        begin
            push_entry.bytes[0] = u2u8_pkg::LEAD_FOUR | {5'd0, code_point[20:18]};
            push_entry.bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, code_point[17:12]};
            push_entry.bytes[2] = u2u8_pkg::CONT_MARK | {2'd0, code_point[11:6]};
            push_entry.bytes[3] = u2u8_pkg::CONT_MARK | {2'd0, code_point[5:0]};
            push_entry.last_idx = 2'd3;
        end
    end

    assign push = accept && !stopped_reg && !is_zero && !is_high;

    // string state update
    always_comb
    begin
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (!stopped_reg)
            begin
                priority if (is_zero)
                begin
                    stopped_next = 1'b1;
                end
                else if (is_high)
                begin
                    pending_next = {1'b0, 10'(unit - u2u8_pkg::HIGH_SUR_FIRST), 10'd0}
                                   + u2u8_pkg::SUPP_BASE;
                end
                else
                begin
                    pending_next = '0;
                end
            end
            if (unit_item.end_of_string)
            begin
                pending_next = '0;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/u2u8_queue.sv
`default_nettype none

module u2u8_queue #(
    parameter int Depth = u2u8_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire u2u8_pkg::enc_entry_t  push_entry,
    input  wire logic                  pop,
    output u2u8_pkg::enc_entry_t       pop_entry,
    output u2u8_pkg::q_status_t        q_status
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    u2u8_pkg::enc_entry_t entries_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign q_status.full  = (count_reg == CntW'(Depth));
    assign q_status.empty = (count_reg == '0);
    assign do_push   = push && !q_status.full;
    assign do_pop    = pop && !q_status.empty;
    assign pop_entry = entries_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/u2u8_back.sv
`default_nettype none

module u2u8_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire u2u8_pkg::q_status_t   q_status,
    input  wire u2u8_pkg::enc_entry_t  pop_entry,
    output logic                       pop,
    output logic                       byte_valid,
    input  wire logic                  byte_stall,
    output u2u8_pkg::byte_item_t       byte_item
);

    u2u8_pkg::enc_entry_t cur_reg;
    logic                 cur_valid_reg;
    logic [1:0]           idx_reg;
    logic                 out_valid_reg;
    u2u8_pkg::byte_item_t out_reg;
    logic                 load_out;
    logic                 send;
    logic                 send_last;

    assign load_out  = !out_valid_reg || !byte_stall;
    assign send      = load_out && cur_valid_reg;
    assign send_last = send && (idx_reg == cur_reg.last_idx);
    assign pop       = !q_status.empty && (!cur_valid_reg || send_last);

    assign byte_valid = out_valid_reg;
    assign byte_item  = out_reg;

    // current entry and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (send_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (send)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_entry;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (send)
        begin
            out_reg.utf8_byte   <= cur_reg.bytes[idx_reg];
            out_reg.last_of_run <= (idx_reg == cur_reg.last_idx);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/utf16_to_utf8_stream_encoder.sv
`default_nettype none

// UTF-16 to UTF-8 stream encoder. Each input item is one 16-bit code unit with an
// end-of-string mark; each output item is one UTF-8 byte, with last_of_run set on the
// final byte produced for that unit. A high surrogate is held and produces nothing until
// its low surrogate arrives, a zero unit stops output until the end mark, and the end
// mark clears all string state. The front end takes one unit per cycle as long as the
// QueueDepth-entry queue of encoded code points has room; the output side sends one byte
// per cycle while byte_stall is low, and a unit yields 1, 2, 3 or 4 bytes by its UTF-8
// length, 4 at worst; units that produce no bytes are handled at the front only.
// The byte serializer and its output register set the sustained rate. An accepted unit
// passes through a queue entry, the serializer's current entry and the output register.
module utf16_to_utf8_stream_encoder #(
    parameter int QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  unit_valid,
    output logic                       unit_stall,
    input  wire u2u8_pkg::unit_item_t  unit_item,
    output logic                       byte_valid,
    input  wire logic                  byte_stall,
    output u2u8_pkg::byte_item_t       byte_item
);

    u2u8_pkg::q_status_t  q_status;
    u2u8_pkg::enc_entry_t push_entry;
    u2u8_pkg::enc_entry_t pop_entry;
    logic                 push;
    logic                 pop;

    // classify units and build code points
    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // encoded code points in flight
    u2u8_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    // byte serializer
    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item)
    );

endmodule

`default_nettype wire

FILE: tb/sv/utf8_stream_checker.sv
module utf8_stream_checker
    import u2u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       unit_valid,
    input  wire logic       unit_stall,
    input  wire unit_item_t unit_item,
    input  wire logic       byte_valid,
    input  wire logic       byte_stall,
    input  wire byte_item_t byte_item,
    output int              fail_count,
    output int              bytes_due,
    output int              bytes_checked
);

    // predicted string state
    logic [20:0] held_point;
    logic        stopped;
    byte_item_t  utf8_due_q[$];

    // append the utf-8 bytes of one code point to the expected stream
    task automatic queue_utf8_bytes(input logic [20:0] cp);
        logic [7:0] seq [4];
        int         n;
        if (cp <= MAX_ONE_BYTE)
        begin
            seq[0] = cp[7:0];
            n = 1;
        end
        else if (cp <= MAX_TWO_BYTE)
        begin
            seq[0] = LEAD_TWO | {3'b000, cp[10:6]};
            seq[1] = CONT_MARK | {2'b00, cp[5:0]};
            n = 2;
        end
        else if (cp <= MAX_THREE_BYTE)
        begin
            seq[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            seq[1] = CONT_MARK | {2'b00, cp[11:6]};
            seq[2] = CONT_MARK | {2'b00, cp[5:0]};
            n = 3;
        end
        else
        begin
            seq[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            seq[1] = CONT_MARK | {2'b00, cp[17:12]};
            seq[2] = CONT_MARK | {2'b00, cp[11:6]};
            seq[3] = CONT_MARK | {2'b00, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            utf8_due_q.push_back('{utf8_byte: seq[k], last_of_run: (k == n - 1)});
        end
    endtask

    // advance the string state by one accepted code unit
    task automatic predict_unit(input unit_item_t u);
        if (!stopped)
        begin
            if (u.code_unit == '0)
            begin
                stopped = 1'b1;
            end
            else if (u.code_unit >= HIGH_SUR_FIRST && u.code_unit <= HIGH_SUR_LAST)
            begin
                held_point = (21'(u.code_unit - HIGH_SUR_FIRST) << 10) + SUPP_BASE;
            end
            else
            begin
                if (u.code_unit >= LOW_SUR_FIRST && u.code_unit <= LOW_SUR_LAST)
                    held_point = held_point | 21'(u.code_unit - LOW_SUR_FIRST);
                else
                    held_point = 21'(u.code_unit);
                queue_utf8_bytes(held_point);
                held_point = '0;
            end
        end
        if (u.end_of_string)
        begin
            held_point = '0;
            stopped = 1'b0;
        end
    endtask

    // watch both channels, predict on units, compare on bytes
    always @(posedge clk or negedge rst_n)
    begin : watch
        byte_item_t due;
        int         errs;
        int         taken;
        if (!rst_n)
        begin
            held_point = '0;
            stopped = 1'b0;
            utf8_due_q.delete();
            fail_count <= 0;
            bytes_due <= 0;
            bytes_checked <= 0;
        end
        else
        begin
            errs = 0;
            taken = 0;
            if (unit_valid && !unit_stall)
                predict_unit(unit_item);
            if (byte_valid && !byte_stall)
            begin
                taken = 1;
                if (utf8_due_q.size() == 0)
                begin
                    $error("byte 0x%02h arrived with no expected byte waiting",
                           byte_item.utf8_byte);
                    errs++;
                end
                else
                begin
                    due = utf8_due_q.pop_front();
                    if (byte_item.utf8_byte !== due.utf8_byte)
                    begin
                        $error("utf8_byte: expected 0x%02h, got 0x%02h",
                               due.utf8_byte, byte_item.utf8_byte);
                        errs++;
                    end
                    if (byte_item.last_of_run !== due.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               due.last_of_run, byte_item.last_of_run);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            bytes_checked <= bytes_checked + taken;
            bytes_due <= utf8_due_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import u2u8_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 12;

    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_HOLD
    } phase_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       unit_valid = 1'b0;
    unit_item_t unit_item  = '0;
    logic       unit_stall;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    byte_item_t byte_item;

    phase_t phase = PH_STEADY;
    int     fail_count;
    int     bytes_due;
    int     bytes_checked;
    int     units_sent = 0;
    int     idle_run   = 0;
    int     hold_count = 0;

    // boundaries, surrogate pairs, lone and dropped surrogates, early stop
    unit_item_t directed_units [25] = '{
        '{16'h0041, 1'b0}, '{16'h007F, 1'b0}, '{16'h0080, 1'b0}, '{16'h07FF, 1'b0},
        '{16'h0800, 1'b0}, '{16'hFFFF, 1'b0}, '{16'hD7FF, 1'b0},
        '{16'hD800, 1'b0}, '{16'hDC00, 1'b0}, '{16'hDBFF, 1'b0}, '{16'hDFFF, 1'b0},
        '{16'hDC00, 1'b0}, '{16'hDFFF, 1'b0},
        '{16'hD83D, 1'b0}, '{16'h0042, 1'b0},
        '{16'hD800, 1'b0}, '{16'hDBFF, 1'b0}, '{16'hDC01, 1'b0},
        '{16'hDABC, 1'b1}, '{16'hDC05, 1'b0},
        '{16'h0000, 1'b0}, '{16'h1234, 1'b0}, '{16'hD800, 1'b0}, '{16'h5678, 1'b1},
        '{16'h00E9, 1'b1}
    };

    always #5 clk = ~clk;

    utf16_to_utf8_stream_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item)
    );

    utf8_stream_checker byte_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .unit_valid    (unit_valid),
        .unit_stall    (unit_stall),
        .unit_item     (unit_item),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_item     (byte_item),
        .fail_count    (fail_count),
        .bytes_due     (bytes_due),
        .bytes_checked (bytes_checked)
    );

    // output side: random stalls per phase, one long hold in the hold phase
    always @(posedge clk)
    begin
        if (phase == PH_HOLD && hold_count < HOLD_CYCLES)
        begin
            byte_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else if (phase == PH_RECV_STALL)
            byte_stall <= ($urandom_range(99) < 58);
        else if (phase == PH_BOTH)
            byte_stall <= ($urandom_range(99) < 38);
        else
            byte_stall <= 1'b0;
    end

    // watchdog on stretches with no item moving
    always @(posedge clk)
    begin
        if ((unit_valid && !unit_stall) || (byte_valid && !byte_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("utf16_to_utf8_stream_encoder: mismatch");
            $finish;
        end
    end

    // offer one code unit, with random gaps ahead of it, until taken
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        int idle_pct;
        idle_pct = (phase == PH_SEND_IDLE) ? 58 : (phase == PH_BOTH) ? 38 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            unit_valid <= 1'b0;
            @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_item <= '{code_unit: cu, end_of_string: eos};
        @(posedge clk);
        while (unit_stall)
            @(posedge clk);
        units_sent++;
    endtask

    // stop offering and wait for every expected byte
    task automatic wait_drained();
        unit_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
    endtask

    // one string of mixed content; units after a zero unit do not count
    task automatic send_random_string(inout int live);
        int         len;
        int         kind;
        logic       halted;
        logic [15:0] cu;
        logic       last;
        len = $urandom_range(1, 10);
        halted = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            kind = $urandom_range(99);
            if (kind < 25)
                cu = 16'($urandom_range(1, 127));
            else if (kind < 40)
                cu = 16'($urandom_range(128, 2047));
            else if (kind < 60)
                cu = $urandom_range(1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                       : 16'($urandom_range(16'hE000, 16'hFFFF));
            else if (kind < 85)
            begin
                send_unit(16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST)), 1'b0);
                if (!halted)
                    live++;
                cu = 16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST));
            end
            else if (kind < 90)
                cu = 16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST));
            else if (kind < 95)
                cu = 16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST));
            else if (kind < 97)
                cu = '0;
            else
                cu = 16'($urandom);
            send_unit(cu, last);
            if (!halted)
                live++;
            if (cu == '0)
                halted = 1'b1;
        end
    endtask

    // drain, switch phase, then random strings
    task automatic run_phase(input phase_t p, input int target);
        int live;
        wait_drained();
        phase <= p;
        @(posedge clk);
        live = 0;
        while (live < target)
            send_random_string(live);
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_units[i])
            send_unit(directed_units[i].code_unit, directed_units[i].end_of_string);

        run_phase(PH_STEADY, 40);
        run_phase(PH_SEND_IDLE, 50);
        run_phase(PH_RECV_STALL, 50);
        run_phase(PH_BOTH, 50);
        run_phase(PH_HOLD, 20);
        run_phase(PH_STEADY, 40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d code units driven, %0d utf-8 bytes checked", units_sent, bytes_checked);
        $display("covered free flow, input gaps, output stalls, both, and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0 && bytes_due == 0)
            $display("utf16_to_utf8_stream_encoder: match");
        else
            $display("utf16_to_utf8_stream_encoder: mismatch");
        $finish;
    end

endmodule

FILE: utf16_to_utf8_stream_encoder.f
hw/rtl/u2u8_pkg.sv
hw/rtl/u2u8_front.sv
hw/rtl/u2u8_queue.sv
hw/rtl/u2u8_back.sv
hw/rtl/utf16_to_utf8_stream_encoder.sv
tb/sv/utf8_stream_checker.sv
tb/sv/testbench.sv
